// File: design/set_assoc_cache_lru_tags_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the set-associative LRU tag store
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_TAGS_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_TAGS_ASSERT_SVH

// Same-cycle implication: the consequent must hold where the antecedent does.
`define SALRU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("salru: assertion failed");

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define SALRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("salru: assertion failed");

`endif

// File: design/salru_pkg.sv
// ---------------------------------------------------------------------------
// salru_pkg
// Types and constants shared by the LRU tag store modules.
// ---------------------------------------------------------------------------
package salru_pkg;

   // Default geometry.
   localparam int DEF_SETS      = 64;
   localparam int DEF_WAYS      = 4;
   localparam int DEF_AGE_WIDTH = 32;

   // Fixed field widths.
   localparam int ADDR_W     = 32;
   localparam int TAG_W      = 32;
   localparam int CNT_W      = 32;
   localparam int WAY_OUT_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // Raw set index is at most seven bits wide, since index_bits holds up to seven.
   localparam int RAW_SET_W = 7;
   localparam int RAW_SET_N = 128;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_WAYS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_BITS = 2'd2;

   // Configuration reset values.
   localparam logic [2:0] RST_WAYS_IN_USE = 3'd4;
   localparam logic [2:0] RST_INDEX_BITS  = 3'd6;
   localparam logic [3:0] RST_OFFSET_BITS = 4'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;   // write a zero row at the sweep pointer
      logic start;   // take the request word and read its set
      logic commit;  // write the row back and load the response
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;  // sweep pointer is at the last row
      logic out_free;    // response register can take a new word
   } status_type;

endpackage

// File: design/salru_if.sv
// ---------------------------------------------------------------------------
// salru interfaces
// Valid/ready channels for requests, responses and register writes.
// ---------------------------------------------------------------------------
interface salru_req_if import salru_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface salru_rsp_if import salru_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [WAY_OUT_W-1:0] way_used;
   logic [CNT_W-1:0]     hit_total;
   logic [CNT_W-1:0]     miss_total;

   modport source (output valid, output hit, output way_used, output hit_total,
                   output miss_total, input ready);
   modport sink   (input valid, input hit, input way_used, input hit_total,
                   input miss_total, output ready);
endinterface

interface salru_csr_if import salru_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/salru_ram.sv
// ---------------------------------------------------------------------------
// salru_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module salru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds between reads.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/salru_ctrl.sv
// ---------------------------------------------------------------------------
// salru_ctrl
// Controller: clearing sweep after reset, then request / lookup sequencing.
// ---------------------------------------------------------------------------
module salru_ctrl import salru_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_LOOKUP: begin
            cmd.commit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: design/salru_dp.sv
// ---------------------------------------------------------------------------
// salru_dp
// Datapath: configuration registers, address split, set row storage,
// hit search, LRU victim tree, counters and the response register.
// ---------------------------------------------------------------------------
module salru_dp import salru_pkg::*; #(
   parameter int SETS      = DEF_SETS,
   parameter int WAYS      = DEF_WAYS,
   parameter int AGE_WIDTH = DEF_AGE_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic [WAY_OUT_W-1:0]  rsp_way_used,
   output logic [CNT_W-1:0]      rsp_hit_total,
   output logic [CNT_W-1:0]      rsp_miss_total
);

   localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int NWAY_W   = $clog2(WAYS + 1);
   localparam int ENTRY_W  = 1 + TAG_W + AGE_WIDTH;
   localparam int ROW_W    = WAYS * ENTRY_W;
   localparam int TREE_LVL = $clog2(WAYS);
   localparam int TREE_P   = 1 << TREE_LVL;

   // Configuration registers.
   logic [2:0] ways_in_use_ff;
   logic [2:0] index_bits_ff;
   logic [3:0] offset_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_in_use_ff <= RST_WAYS_IN_USE;
         index_bits_ff  <= RST_INDEX_BITS;
         offset_bits_ff <= RST_OFFSET_BITS;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WAYS_IN_USE: ways_in_use_ff <= csr_data[2:0];
            REG_INDEX_BITS:  index_bits_ff  <= csr_data[2:0];
            REG_OFFSET_BITS: offset_bits_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Raw set index wraps onto the set count through a constant table.
   logic [SET_W-1:0] set_tbl [RAW_SET_N];

   for (genvar g = 0; g < RAW_SET_N; g++) begin : g_set_tbl
      assign set_tbl[g] = SET_W'(g % SETS);
   end

   // Address split into set and tag.
   logic [ADDR_W-1:0]    addr_shifted;
   logic [RAW_SET_W-1:0] set_mask;
   logic [RAW_SET_W-1:0] set_raw;
   logic [SET_W-1:0]     set_idx;
   logic [4:0]           tag_shamt;
   logic [TAG_W-1:0]     tag_new;

   always_comb begin
      addr_shifted = req_address >> offset_bits_ff;
      set_mask     = RAW_SET_W'((8'd1 << index_bits_ff) - 8'd1);
      set_raw      = addr_shifted[RAW_SET_W-1:0] & set_mask;
      set_idx      = set_tbl[set_raw];
      tag_shamt    = 5'(offset_bits_ff) + 5'(index_bits_ff);
      tag_new      = TAG_W'(req_address >> tag_shamt);
   end

   // Request word latched at acceptance.
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         set_ff <= set_idx;
         tag_ff <= tag_new;
      end
   end

   // Clearing sweep pointer.
   logic [SET_W-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + SET_W'(1);
      end
   end

   // Set row storage: one row holds valid, tag and age for every way.
   logic [ROW_W-1:0] row_rd;
   logic [ROW_W-1:0] row_new;
   logic             ram_wr_en;
   logic [SET_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;

   assign ram_wr_en   = cmd.clear | cmd.commit;
   assign ram_wr_addr = cmd.clear ? clr_cnt_ff : set_ff;
   assign ram_wr_data = cmd.clear ? '0 : row_new;

   salru_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.start),
      .rd_addr (set_idx),
      .rd_data (row_rd)
   );

   // Active way count, clamped to one through WAYS.
   logic [NWAY_W-1:0] nways;

   always_comb begin
      if (ways_in_use_ff == 3'd0) begin
         nways = NWAY_W'(1);
      end else if (int'(ways_in_use_ff) > WAYS) begin
         nways = NWAY_W'(WAYS);
      end else begin
         nways = NWAY_W'(ways_in_use_ff);
      end
   end

   // Unpack the row and age every active way.
   logic                 ent_valid [WAYS];
   logic [TAG_W-1:0]     ent_tag   [WAYS];
   logic [AGE_WIDTH-1:0] ent_age   [WAYS];
   logic [AGE_WIDTH-1:0] age_inc   [WAYS];
   logic                 active    [WAYS];
   logic                 match     [WAYS];

   for (genvar g = 0; g < WAYS; g++) begin : g_way
      assign ent_age[g]   = row_rd[g*ENTRY_W +: AGE_WIDTH];
      assign ent_tag[g]   = row_rd[g*ENTRY_W + AGE_WIDTH +: TAG_W];
      assign ent_valid[g] = row_rd[g*ENTRY_W + AGE_WIDTH + TAG_W];
      assign active[g]    = (NWAY_W'(g) < nways);
      assign age_inc[g]   = ent_age[g] + AGE_WIDTH'(1);
      assign match[g]     = active[g] & ent_valid[g] & (ent_tag[g] == tag_ff);
   end

   // Hit search: the lowest matching way wins.
   logic             hit;
   logic [WAY_W-1:0] hit_way;

   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
   end

   // Victim tree: oldest active way, ties go to the lower way.
   logic                 lf_cand [TREE_P];
   logic [AGE_WIDTH-1:0] lf_age  [TREE_P];

   for (genvar g = 0; g < TREE_P; g++) begin : g_leaf
      if (g < WAYS) begin : g_real
         assign lf_cand[g] = active[g];
         assign lf_age[g]  = age_inc[g];
      end else begin : g_pad
         assign lf_cand[g] = 1'b0;
         assign lf_age[g]  = '0;
      end
   end

   logic                 nd_cand [1:2*TREE_P-1];
   logic [AGE_WIDTH-1:0] nd_age  [1:2*TREE_P-1];
   logic [WAY_W-1:0]     nd_way  [1:2*TREE_P-1];
   logic [WAY_W-1:0]     victim;

   always_comb begin
      for (int n = 0; n < TREE_P; n++) begin
         nd_cand[TREE_P+n] = lf_cand[n];
         nd_age[TREE_P+n]  = lf_age[n];
         nd_way[TREE_P+n]  = WAY_W'(n);
      end
      for (int n = TREE_P - 1; n >= 1; n--) begin
         if (nd_cand[2*n+1] && (!nd_cand[2*n] || (nd_age[2*n+1] > nd_age[2*n]))) begin
            nd_cand[n] = nd_cand[2*n+1];
            nd_age[n]  = nd_age[2*n+1];
            nd_way[n]  = nd_way[2*n+1];
         end else begin
            nd_cand[n] = nd_cand[2*n];
            nd_age[n]  = nd_age[2*n];
            nd_way[n]  = nd_way[2*n];
         end
      end
      victim = nd_way[1];
   end

   // Updated row: aged active ways, used way cleared, victim refilled.
   logic [WAY_W-1:0] used_way;

   assign used_way = hit ? hit_way : victim;

   always_comb begin
      row_new = row_rd;
      for (int w = 0; w < WAYS; w++) begin
         if (active[w]) begin
            row_new[w*ENTRY_W +: AGE_WIDTH] = age_inc[w];
            if (WAY_W'(w) == used_way) begin
               row_new[w*ENTRY_W +: AGE_WIDTH] = '0;
               if (!hit) begin
                  row_new[w*ENTRY_W + AGE_WIDTH +: TAG_W] = tag_ff;
                  row_new[w*ENTRY_W + AGE_WIDTH + TAG_W]  = 1'b1;
               end
            end
         end
      end
   end

   // Hit and miss totals; they also drive the response directly.
   logic [CNT_W-1:0] hit_cnt_ff;
   logic [CNT_W-1:0] miss_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else if (cmd.commit) begin
         hit_cnt_ff  <= hit_cnt_ff + CNT_W'(hit);
         miss_cnt_ff <= miss_cnt_ff + CNT_W'(!hit);
      end
   end

   // Response register.
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [WAY_OUT_W-1:0] rsp_way_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff <= hit;
         rsp_way_ff <= WAY_OUT_W'(used_way);
      end
   end

   assign status.clear_last = (clr_cnt_ff == SET_W'(SETS - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_way_used   = rsp_way_ff;
   assign rsp_hit_total  = hit_cnt_ff;
   assign rsp_miss_total = miss_cnt_ff;

endmodule

// File: design/set_assoc_cache_lru_tags.sv
// A request is taken in the idle state, which reads its set row from the
// single row RAM; the lookup state writes the row back and loads the response
// register once it is free, and no new request is taken before that.
// Reset: synchronous; afterwards a sweep of the row RAM zeroes every row
// (valid bits, tags and ages) while requests are held off; register writes
// are taken at all times.
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_tags
// Tag store of a set-associative cache with age-counter LRU replacement.
// ---------------------------------------------------------------------------
module set_assoc_cache_lru_tags import salru_pkg::*; #(
   parameter int SETS      = DEF_SETS,
   parameter int WAYS      = DEF_WAYS,
   parameter int AGE_WIDTH = DEF_AGE_WIDTH
) (
   input logic         clock,
   input logic         reset,
   salru_req_if.sink   req_if,
   salru_rsp_if.source rsp_if,
   salru_csr_if.sink   csr_if
);

   cmd_type    cmd;
   status_type status;

   // Register writes are always taken.
   assign csr_if.ready = 1'b1;

   salru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   salru_dp #(
      .SETS      (SETS),
      .WAYS      (WAYS),
      .AGE_WIDTH (AGE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_address    (req_if.address),
      .csr_valid      (csr_if.valid),
      .csr_index      (csr_if.index),
      .csr_data       (csr_if.data),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_hit        (rsp_if.hit),
      .rsp_way_used   (rsp_if.way_used),
      .rsp_hit_total  (rsp_if.hit_total),
      .rsp_miss_total (rsp_if.miss_total)
   );

endmodule

// File: design/salru_chk.sv
// ---------------------------------------------------------------------------
// salru_chk
// Port-level checks on the tag store, bound to the top level.
// ---------------------------------------------------------------------------
`include "set_assoc_cache_lru_tags_assert.svh"

module salru_chk import salru_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_hit,
   input logic [WAY_OUT_W-1:0] rsp_way_used,
   input logic [CNT_W-1:0]     rsp_hit_total,
   input logic [CNT_W-1:0]     rsp_miss_total
);

   // One access at a time: no request is taken right after another.
   `SALRU_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   // A fresh response word always follows an accepted request.
   `SALRU_ASSERT_NOW(a_rsp_latency, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))

   // A fresh response bumps exactly the total that matches its hit flag.
   `SALRU_ASSERT_NOW(a_total_step, clock, reset, $rose(rsp_valid), (rsp_hit && rsp_hit_total == $past(rsp_hit_total) + 32'd1 && $stable(rsp_miss_total)) || (!rsp_hit && rsp_miss_total == $past(rsp_miss_total) + 32'd1 && $stable(rsp_hit_total)))

   // A stalled response word holds.
   `SALRU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_way_used) && $stable(rsp_hit_total) && $stable(rsp_miss_total))

endmodule

bind set_assoc_cache_lru_tags salru_chk u_salru_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_hit        (rsp_if.hit),
   .rsp_way_used   (rsp_if.way_used),
   .rsp_hit_total  (rsp_if.hit_total),
   .rsp_miss_total (rsp_if.miss_total)
);

// File: test/lru_tag_checker.sv
// ---------------------------------------------------------------------------
// lru_tag_checker
// Watches the request, response and register channels of the LRU tag store.
// It keeps its own copy of the tags, valid bits, ages and totals, works out
// the expected response word for every accepted request, and compares each
// accepted response word against the oldest expectation.
// ---------------------------------------------------------------------------
module lru_tag_checker import salru_pkg::*; #(
   parameter int SETS      = DEF_SETS,
   parameter int WAYS      = DEF_WAYS,
   parameter int AGE_WIDTH = DEF_AGE_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   salru_req_if        req,
   salru_rsp_if        rsp,
   salru_csr_if        csr,
   output int          fail_count,
   output int          pending,
   output int          hit_words,
   output int          miss_words
);
   timeunit 1ns;
   timeprecision 1ps;

   // One response word as the block should present it.
   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic [CNT_W-1:0]     hits;
      logic [CNT_W-1:0]     misses;
   } lookup_word_type;

   // Shadow copy of the register settings.
   logic [2:0] ways_cfg;
   logic [2:0] index_cfg;
   logic [3:0] offset_cfg;

   // Shadow copy of the tag store, valid bits, ages and totals.
   logic [TAG_W-1:0]     tag_mem   [SETS*WAYS];
   logic                 valid_mem [SETS*WAYS];
   logic [AGE_WIDTH-1:0] age_mem   [SETS*WAYS];
   logic [CNT_W-1:0]     hit_cnt;
   logic [CNT_W-1:0]     miss_cnt;

   lookup_word_type expected_words[$];
   int mismatch_n = 0;
   int hit_n      = 0;
   int miss_n     = 0;

   // Performs one lookup on the shadow store and returns the response word.
   function automatic lookup_word_type predict_lookup(input logic [ADDR_W-1:0] addr);
      int unsigned          ways_eff;
      int unsigned          set_sel;
      int unsigned          base;
      int unsigned          used;
      int unsigned          w;
      logic [ADDR_W-1:0]    set_mask;
      logic [TAG_W-1:0]     tag;
      logic [AGE_WIDTH-1:0] oldest;
      logic                 found;
      lookup_word_type      r;

      // A way count of zero acts as one; counts above the array size saturate.
      if (ways_cfg == 3'd0) begin
         ways_eff = 1;
      end else if (ways_cfg > WAYS) begin
         ways_eff = WAYS;
      end else begin
         ways_eff = ways_cfg;
      end
      set_mask = (32'd1 << index_cfg) - 32'd1;
      set_sel  = ((addr >> offset_cfg) & set_mask) % SETS;
      tag      = addr >> (int'(offset_cfg) + int'(index_cfg));
      base     = set_sel * WAYS;

      // Every active way of the set grows one step older.
      for (w = 0; w < ways_eff; w++) begin
         age_mem[base+w] = age_mem[base+w] + 1'b1;
      end

      // The first valid way with a matching tag is the hit.
      found = 1'b0;
      used  = 0;
      for (w = 0; w < ways_eff; w++) begin
         if (!found && valid_mem[base+w] && tag_mem[base+w] == tag) begin
            found = 1'b1;
            used  = w;
         end
      end

      if (found) begin
         age_mem[base+used] = '0;
         hit_cnt = hit_cnt + 1'b1;
      end else begin
         // Victim is the first way holding the strictly greatest age.
         miss_cnt = miss_cnt + 1'b1;
         oldest   = '0;
         for (w = 0; w < ways_eff; w++) begin
            if (age_mem[base+w] > oldest) begin
               oldest = age_mem[base+w];
               used   = w;
            end
         end
         tag_mem[base+used]   = tag;
         valid_mem[base+used] = 1'b1;
         age_mem[base+used]   = '0;
      end

      r.hit    = found;
      r.way    = used[WAY_OUT_W-1:0];
      r.hits   = hit_cnt;
      r.misses = miss_cnt;
      return r;
   endfunction

   // All three channels are sampled at the rising edge, before any update.
   always @(posedge clock) begin : watch
      lookup_word_type want;

      if (reset) begin
         ways_cfg   = RST_WAYS_IN_USE;
         index_cfg  = RST_INDEX_BITS;
         offset_cfg = RST_OFFSET_BITS;
         for (int i = 0; i < SETS*WAYS; i++) begin
            tag_mem[i]   = '0;
            valid_mem[i] = 1'b0;
            age_mem[i]   = '0;
         end
         hit_cnt  = '0;
         miss_cnt = '0;
         expected_words.delete();
      end else begin
         // A response word is checked before a request in the same cycle is
         // predicted, since it always belongs to an earlier request.
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               if (mismatch_n < 10) begin
                  $display("%0t: response word with nothing outstanding: hit=%0d way=%0d",
                           $realtime, rsp.hit, rsp.way_used);
               end
               mismatch_n++;
            end else begin
               want = expected_words.pop_front();
               if (want.hit) hit_n++;
               else miss_n++;
               if (rsp.hit !== want.hit || rsp.way_used !== want.way ||
                   rsp.hit_total !== want.hits || rsp.miss_total !== want.misses) begin
                  if (mismatch_n < 10) begin
                     $display("%0t: expected hit=%0d way=%0d hits=%0d misses=%0d",
                              $realtime, want.hit, want.way, want.hits, want.misses);
                     $display("%0t:      got hit=%0d way=%0d hits=%0d misses=%0d",
                              $realtime, rsp.hit, rsp.way_used, rsp.hit_total,
                              rsp.miss_total);
                  end
                  mismatch_n++;
               end
            end
         end

         // Register writes only take the bits each register holds.
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_WAYS_IN_USE: ways_cfg   = csr.data[2:0];
               REG_INDEX_BITS:  index_cfg  = csr.data[2:0];
               REG_OFFSET_BITS: offset_cfg = csr.data[3:0];
               default: ;
            endcase
         end

         if (req.valid && req.ready) begin
            expected_words.push_back(predict_lookup(req.address));
         end
      end

      fail_count <= mismatch_n;
      pending    <= expected_words.size();
      hit_words  <= hit_n;
      miss_words <= miss_n;
   end

endmodule

// File: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Regression for the set-associative LRU tag store. A short directed run
// covers address extremes, hits, evictions, zero and oversized way counts
// and set-index wrap; then random lookups with strong set locality run under
// a range of register settings, with bursty requests, random response
// stalls and one long response hold-off. A separate checker predicts and
// compares every response word.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import salru_pkg::*;

   localparam int LIMIT      = 200000;
   localparam int LONG_HOLD  = 300;
   localparam int RAND_ITEMS = 59;

   // Directed addresses under the reset settings: tag in bits 31:8, set in 7:2.
   localparam logic [ADDR_W-1:0] DIR_DEFAULT [10] = '{
      32'h0000_0000, 32'h0000_0003, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h0000_0100,
      32'h0000_0200, 32'h0000_0300, 32'h0000_0400, 32'h0000_0000, 32'h0000_0300
   };
   // One way, seven index bits, offset of fifteen: index 64 and 65 wrap.
   localparam logic [ADDR_W-1:0] DIR_WRAP [4] = '{
      32'h0020_0000, 32'h0000_0000, 32'h0020_8000, 32'hFFC0_0000
   };
   // Oversized way count and a single set: the tag is the whole address.
   localparam logic [ADDR_W-1:0] DIR_ONE_SET [6] = '{
      32'h1234_5678, 32'h1234_5678, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF,
      32'h1234_5678
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   salru_req_if req ();
   salru_rsp_if rsp ();
   salru_csr_if csr ();

   int fail_count;
   int pending;
   int hit_words;
   int miss_words;

   int   cycle_n       = 0;
   int   burst_left    = 0;
   int   settings_run  = 0;
   bit   req_up        = 1'b0;
   bit   long_hold_due = 1'b0;
   logic [2:0] cur_ways   = RST_WAYS_IN_USE;
   logic [2:0] cur_index  = RST_INDEX_BITS;
   logic [3:0] cur_offset = RST_OFFSET_BITS;

   set_assoc_cache_lru_tags dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   lru_tag_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr        (csr),
      .fail_count (fail_count),
      .pending    (pending),
      .hit_words  (hit_words),
      .miss_words (miss_words)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
      if (cycle_n == LIMIT) begin
         $display("set_assoc_cache_lru_tags regression: fail");
         $finish;
      end
   end

   // Response side: ready follows a changing pattern, with one long hold-off
   // on request so the block backs up into its request channel.
   initial begin : rsp_drain
      int mode;
      int span;

      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = (mode == 3) ? $urandom_range(1, 6) : $urandom_range(1, 24);
         repeat (span) begin
            case (mode)
               0:       rsp.ready <= 1'b1;
               1:       rsp.ready <= 1'($urandom_range(0, 1));
               2:       rsp.ready <= ($urandom_range(0, 3) != 0);
               default: rsp.ready <= 1'b0;
            endcase
            @(posedge clock);
         end
      end
   end

   // Offers one address word and waits for it to be taken. Requests come in
   // bursts; a gap of idle cycles follows the end of each burst.
   task automatic send_lookup(input logic [ADDR_W-1:0] addr);
      int gap;

      req.valid   <= 1'b1;
      req.address <= addr;
      req_up = 1'b1;
      do @(posedge clock); while (!req.ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 8);
         gap = $urandom_range(1, 7);
         req.valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops requests and waits until every outstanding response has arrived.
   task automatic drain_lookups();
      if (req_up) begin
         req.valid <= 1'b0;
         req_up = 1'b0;
      end
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Writes all three registers back to back. The unused top data bit of the
   // narrower registers is filled at random.
   task automatic write_settings(input logic [2:0] ways, input logic [2:0] idx_bits,
                                 input logic [3:0] off_bits);
      logic [CSR_IDX_W-1:0]  reg_sel [3];
      logic [CSR_DATA_W-1:0] value   [3];

      reg_sel = '{REG_WAYS_IN_USE, REG_INDEX_BITS, REG_OFFSET_BITS};
      value   = '{{1'($urandom_range(0, 1)), ways}, {1'($urandom_range(0, 1)), idx_bits},
                  off_bits};
      for (int i = 0; i < 3; i++) begin
         csr.valid <= 1'b1;
         csr.index <= reg_sel[i];
         csr.data  <= value[i];
         do @(posedge clock); while (!csr.ready);
      end
      csr.valid <= 1'b0;
      cur_ways   = ways;
      cur_index  = idx_bits;
      cur_offset = off_bits;
      settings_run++;
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      logic [2:0]        ways_list   [9];
      logic [2:0]        index_list  [9];
      logic [3:0]        offset_list [9];
      logic [ADDR_W-1:0] pool [$];
      logic [ADDR_W-1:0] set_bits;
      logic [ADDR_W-1:0] off_mask;
      logic [ADDR_W-1:0] addr;
      int                shift;
      int                set_cnt;
      int                ways_eff;

      ways_list   = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd7, 3'd4, 3'd2};
      index_list  = '{3'd6, 3'd6, 3'd3, 3'd0, 3'd7, 3'd2, 3'd5, 3'd1, 3'd6};
      offset_list = '{4'd2, 4'd10, 4'd0, 4'd5, 4'd15, 4'd1, 4'd8, 4'd3, 4'd10};

      req.valid   <= 1'b0;
      req.address <= '0;
      csr.valid   <= 1'b0;
      csr.index   <= REG_WAYS_IN_USE;
      csr.data    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: address extremes, hits, fills and evictions of one set.
      foreach (DIR_DEFAULT[i]) send_lookup(DIR_DEFAULT[i]);
      drain_lookups();

      // Directed: zero way count and set index past the array.
      write_settings(3'd0, 3'd7, 4'd15);
      foreach (DIR_WRAP[i]) send_lookup(DIR_WRAP[i]);
      drain_lookups();

      // Directed: oversized way count with a single set.
      write_settings(3'd7, 3'd0, 4'd0);
      foreach (DIR_ONE_SET[i]) send_lookup(DIR_ONE_SET[i]);
      drain_lookups();

      // Random lookups. Most addresses come from a small pool of tags in a
      // few sets, a little larger than the ways, so hits and evictions mix.
      foreach (ways_list[p]) begin
         write_settings(ways_list[p], index_list[p], offset_list[p]);
         if (p == 2) long_hold_due = 1'b1;
         ways_eff = (cur_ways == 3'd0) ? 1 : ((cur_ways > DEF_WAYS) ? DEF_WAYS : cur_ways);
         shift    = int'(cur_offset) + int'(cur_index);
         off_mask = (32'd1 << cur_offset) - 32'd1;
         set_cnt  = $urandom_range(1, 3);
         pool.delete();
         for (int s = 0; s < set_cnt; s++) begin
            set_bits = ($urandom & ((32'd1 << cur_index) - 32'd1)) << cur_offset;
            for (int t = 0; t < ways_eff + 2; t++) begin
               pool.push_back(($urandom << shift) | set_bits);
            end
         end
         for (int n = 0; n < RAND_ITEMS; n++) begin
            if ($urandom_range(0, 3) != 0) begin
               addr = pool[$urandom_range(0, pool.size() - 1)] | ($urandom & off_mask);
            end else begin
               addr = $urandom;
            end
            send_lookup(addr);
         end
         drain_lookups();
      end

      // Let the last responses settle before the verdict.
      repeat (8) @(posedge clock);
      $display("Checked %0d lookups (%0d hits, %0d misses) across %0d register settings.",
               hit_words + miss_words, hit_words, miss_words, settings_run);
      $display("Included zero and oversized way counts, set-index wrap and a long stall.");
      if (fail_count == 0 && pending == 0) begin
         $display("set_assoc_cache_lru_tags regression: pass");
      end else begin
         $display("set_assoc_cache_lru_tags regression: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/salru_pkg.sv
design/salru_if.sv
design/salru_ram.sv
design/salru_ctrl.sv
design/salru_dp.sv
design/set_assoc_cache_lru_tags.sv
design/salru_chk.sv
test/lru_tag_checker.sv
test/tb.sv
